FILE: sv/slt_pkg.sv
// Shared types and constants for the sorted list table.
package slt_pkg;

  localparam int DataW = 32;
  localparam int InTdataW = 40;
  localparam int OutTdataW = 40;
  localparam int CountOutW = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_INS_PUT,
    S_SRCH_RD,
    S_SRCH_EV,
    S_POP_EV,
    S_SHD,
    S_SHD_EV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

FILE: sv/sorted_list_table_core.sv
// Top level: entry memory and sequencer of the sorted list table.
// Insert compares entries from the tail, moving each larger-or-equal one up; search and delete
// scan from the head, and a delete that finds its key shifts the later entries down; pop reads
// the head and shifts the rest down; full/empty cases go straight to the result; a held output register stalls.
// Throughput: one item at a time; the next item is accepted while a result waits.
// Synchronous reset empties the list; the entry memory is not cleared.
module sorted_list_table_core
  import slt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [InTdataW-1:0]  s_tdata,   // opcode[1:0], key_value[33:2], zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutTdataW-1:0] m_tdata    // status[1:0], popped_value[33:2],
                                          // entry_count[38:34], zero pad
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] CapCount = IW'(CAPACITY);

  state_t                 state, state_next;
  opcode_t                op, op_next;
  logic [DataW-1:0]       key, key_next;
  logic [IW-1:0]          idx, idx_next;
  logic [IW-1:0]          count, count_next;
  status_t                res_status, res_status_next;
  logic [DataW-1:0]       res_popped, res_popped_next;
  logic                   out_valid, out_valid_next;
  logic [OutTdataW-1:0]   out_data, out_data_next;

  logic [DataW-1:0]       mem [CAPACITY];
  logic [DataW-1:0]       rdata;
  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [DataW-1:0]       wdata;

  cmp_res_t               cmp;
  logic [IW-1:0]          idx_p1, idx_m1;
  logic [31:0]            cnt_ext;
  opcode_t                in_op;
  logic [DataW-1:0]       in_key;

  assign in_op  = opcode_t'(s_tdata[1:0]);
  assign in_key = s_tdata[DataW+1:2];
  assign idx_p1 = idx + IW'(1);
  assign idx_m1 = idx - IW'(1);
  assign cnt_ext = 32'(count);

  slt_cmp u_cmp (
    .a   (rdata),
    .b   (key),
    .res (cmp)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    op         <= op_next;
    key        <= key_next;
    idx        <= idx_next;
    res_status <= res_status_next;
    res_popped <= res_popped_next;
    out_data   <= out_data_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    idx_next        = idx;
    count_next      = count;
    res_status_next = res_status;
    res_popped_next = res_popped;
    out_valid_next  = out_valid && !m_tready;
    out_data_next   = out_data;
    we              = 1'b0;
    waddr           = idx[AW-1:0];
    wdata           = key;
    raddr           = '0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_next         = in_op;
          key_next        = in_key;
          res_status_next = ST_OK;
          res_popped_next = '0;
          idx_next        = '0;
          case (in_op)
            OP_INSERT: begin
              if (count == CapCount) begin
                res_status_next = ST_FULL;
                state_next      = S_DONE;
              end else begin
                idx_next   = count;
                state_next = (count == '0) ? S_INS_PUT : S_INS_RD;
              end
            end
            OP_SEARCH, OP_DELETE: begin
              if (count == '0) begin
                res_status_next = ST_NOT_FOUND;
                state_next      = S_DONE;
              end else begin
                state_next = S_SRCH_RD;
              end
            end
            OP_POP: begin
              // address 0 is read this cycle, so the head is ready next cycle
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_DONE;
              end else begin
                state_next = S_POP_EV;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        raddr      = idx_m1[AW-1:0];
        state_next = S_INS_EV;
      end
      S_INS_EV: begin
        if (cmp.lt) begin
          state_next = S_INS_PUT;
        end else begin
          // move the larger-or-equal entry up one place
          we         = 1'b1;
          wdata      = rdata;
          idx_next   = idx_m1;
          state_next = (idx == IW'(1)) ? S_INS_PUT : S_INS_RD;
        end
      end
      S_INS_PUT: begin
        we         = 1'b1;
        count_next = count + IW'(1);
        state_next = S_DONE;
      end
      S_SRCH_RD: begin
        raddr      = idx[AW-1:0];
        state_next = S_SRCH_EV;
      end
      S_SRCH_EV: begin
        if (cmp.eq) begin
          state_next = (op == OP_DELETE) ? S_SHD : S_DONE;
        end else if (idx_p1 == count) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          idx_next   = idx_p1;
          state_next = S_SRCH_RD;
        end
      end
      S_POP_EV: begin
        res_popped_next = rdata;
        state_next      = S_SHD;
      end
      S_SHD: begin
        if (idx_p1 >= count) begin
          count_next = count - IW'(1);
          state_next = S_DONE;
        end else begin
          raddr      = idx_p1[AW-1:0];
          state_next = S_SHD_EV;
        end
      end
      S_SHD_EV: begin
        we         = 1'b1;
        wdata      = rdata;
        idx_next   = idx_p1;
        state_next = S_SHD;
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {1'b0, cnt_ext[CountOutW-1:0], res_popped, res_status};
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

FILE: sv/slt_cmp.sv
// Shared signed comparator used by the insert and search/delete scan steps.
module slt_cmp
  import slt_pkg::*;
(
  input  logic [DataW-1:0] a,
  input  logic [DataW-1:0] b,
  output cmp_res_t         res
);

  assign res.lt = $signed(a) < $signed(b);
  assign res.eq = (a == b);

endmodule

FILE: verif/tb_sorted_list_table_core.sv
// Testbench for sorted_list_table_core: list prediction, random streams and result checks.
module tb_sorted_list_table_core;
  import slt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cap = 16;
  localparam logic signed [DataW-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] KeyMax = 32'sh7fff_ffff;

  typedef struct {
    opcode_t                  op;
    logic signed [DataW-1:0]  key;
  } list_cmd_t;

  typedef struct {
    status_t                  st;
    logic signed [DataW-1:0]  popped;
    logic [CountOutW-1:0]     cnt;
  } list_reply_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OutTdataW-1:0] m_tdata;

  sorted_list_table_core #(.CAPACITY(Cap)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  list_cmd_t               pending_cmds[$];
  list_reply_t             awaited_replies[$];
  logic signed [DataW-1:0] held_keys[$];   // predicted list contents, ascending

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic took_in = 1'b0;

  int n_fail = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_missing = 0;
  int n_popped = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("%0t: timeout with %0d items pending, %0d results awaited", $realtime,
             pending_cmds.size(), awaited_replies.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Applies one command to the predicted list and returns the reply it should give.
  function automatic list_reply_t apply_to_list(opcode_t op, logic signed [DataW-1:0] key);
    list_reply_t r;
    int pos;
    r.st = ST_OK;
    r.popped = '0;
    case (op)
      OP_INSERT: begin
        if (held_keys.size() >= Cap) begin
          r.st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_keys.size() && held_keys[pos] < key) pos++;
          held_keys.insert(pos, key);
        end
      end
      OP_SEARCH: begin
        r.st = ST_NOT_FOUND;
        foreach (held_keys[i]) if (held_keys[i] == key) r.st = ST_OK;
      end
      OP_DELETE: begin
        r.st = ST_NOT_FOUND;
        pos = -1;
        foreach (held_keys[i]) if (pos < 0 && held_keys[i] == key) pos = i;
        if (pos >= 0) begin
          held_keys.delete(pos);
          r.st = ST_OK;
        end
      end
      default: begin
        if (held_keys.size() == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.popped = held_keys.pop_front();
        end
      end
    endcase
    r.cnt = CountOutW'(held_keys.size());
    return r;
  endfunction

  // Driver: holds an offered item until taken, then offers the next one.
  always @(negedge clk) begin
    list_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || took_in) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, c.key, c.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on every accepted item, checks every accepted result.
  always @(posedge clk) begin
    list_reply_t want;
    logic [1:0]           got_st;
    logic [DataW-1:0]     got_pop;
    logic [CountOutW-1:0] got_cnt;
    took_in <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      awaited_replies.push_back(apply_to_list(opcode_t'(s_tdata[1:0]), s_tdata[33:2]));
    end
    if (!rst && m_tvalid && m_tready) begin
      got_st  = m_tdata[1:0];
      got_pop = m_tdata[33:2];
      got_cnt = m_tdata[38:34];
      if (awaited_replies.size() == 0) begin
        $display("%0t: result with none expected: st=%0d pop=%0d cnt=%0d", $realtime,
                 got_st, $signed(got_pop), got_cnt);
        n_fail++;
      end else begin
        want = awaited_replies.pop_front();
        n_checked++;
        if (want.st === ST_FULL) n_full++;
        if (want.st === ST_EMPTY) n_empty++;
        if (want.st === ST_NOT_FOUND) n_missing++;
        if (want.st === ST_OK && got_pop !== '0) n_popped++;
        if (got_st !== want.st || got_pop !== want.popped || got_cnt !== want.cnt) begin
          $display("%0t: mismatch: expected st=%0d pop=%0d cnt=%0d, got st=%0d pop=%0d cnt=%0d",
                   $realtime, want.st, want.popped, want.cnt,
                   got_st, $signed(got_pop), got_cnt);
          n_fail++;
        end
      end
    end
  end

  task automatic queue_cmd(opcode_t op, logic signed [DataW-1:0] key);
    list_cmd_t c;
    c.op = op;
    c.key = key;
    pending_cmds.push_back(c);
  endtask

  function automatic logic signed [DataW-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $signed($urandom_range(12)) - 6;   // dense range, many repeats
    if (r < 62) begin
      case ($urandom_range(5))
        0: return KeyMin;
        1: return KeyMax;
        2: return KeyMin + 1;
        3: return KeyMax - 1;
        4: return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // Fill-heavy, drain-heavy and even stretches so full and empty both come round.
  task automatic queue_random(int n);
    int mode;
    int r;
    opcode_t op;
    mode = 2;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) mode = $urandom_range(2);
      r = $urandom_range(99);
      case (mode)
        0: op = (r < 65) ? OP_INSERT : (r < 75) ? OP_SEARCH : (r < 85) ? OP_DELETE : OP_POP;
        1: op = (r < 15) ? OP_INSERT : (r < 25) ? OP_SEARCH : (r < 55) ? OP_DELETE : OP_POP;
        default: op = opcode_t'(r % 4);
      endcase
      queue_cmd(op, pick_key());
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || s_tvalid || awaited_replies.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty list cases, extremes, duplicates, then fill past capacity
    queue_cmd(OP_POP, 32'sd5);
    queue_cmd(OP_SEARCH, 0);
    queue_cmd(OP_DELETE, 0);
    queue_cmd(OP_INSERT, KeyMax);
    queue_cmd(OP_INSERT, KeyMin);
    queue_cmd(OP_INSERT, 0);
    queue_cmd(OP_INSERT, 0);
    queue_cmd(OP_INSERT, -1);
    queue_cmd(OP_SEARCH, 0);
    queue_cmd(OP_SEARCH, 32'sd5);
    queue_cmd(OP_DELETE, 0);
    queue_cmd(OP_DELETE, 32'sd7);
    for (int i = 0; i < 12; i++) queue_cmd(OP_INSERT, $signed(32'h5a5a_5a5a ^ (i << 27)));
    queue_cmd(OP_INSERT, 32'sd3);
    queue_cmd(OP_POP, KeyMax);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      queue_random(331);
      wait_drained();
    end

    repeat (80) @(posedge clk);
    $display("Checked %0d results over four handshake phases: %0d inserts refused as full,",
             n_checked, n_full);
    $display("%0d pops on an empty list, %0d keys not found, %0d non-zero values popped.",
             n_empty, n_missing, n_popped);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
